[hdl/bldq_pkg.sv]
// shared types and codes for the bounded deque with search
package bldq_pkg;

	// operation codes
	localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
	localparam logic [2:0] OP_POP_FRONT  = 3'd2;
	localparam logic [2:0] OP_POP_BACK   = 3'd3;
	localparam logic [2:0] OP_SEARCH     = 3'd4;
	localparam logic [2:0] OP_CLEAR      = 3'd5;

	// status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_ERR  = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	// default sizes
	localparam int DEPTH_DEF      = 16;
	localparam int DATA_WIDTH_DEF = 32;

	// per-cycle command broadcast to every cell
	typedef struct packed {
		logic shift_r;  // move toward the back, front cell takes the new value
		logic shift_l;  // move toward the front
		logic append;   // cell at the current count takes the new value
	} cell_ctrl_t;

endpackage

[hdl/bounded_list_deque_with_search_top.sv]
// top level of the bounded deque with membership search
//
// Usage: drive func and data_value with start high; an item is taken at a
// clock edge where start is high and busy is low. busy is high only while
// the block comes out of reset and low otherwise, so one item per cycle can
// be issued back to back.
// Each item gives exactly one result: done pulses for one cycle, the cycle
// after the item was taken, with status and entry_count (count after the
// operation). The receiver cannot stall; the result is valid only in the
// done cycle.
// Throughput 1 item per cycle: the row of DEPTH cells
// shifts for front pushes and pops and compares every entry against the
// key in parallel, so the cost of a cycle is one compare per cell plus the
// OR over all match bits.
// Reset clears the count (store empty) and the result strobe; entry
// contents are left as they are and are never read before written.
module bounded_list_deque_with_search_top #(
	parameter int DEPTH      = bldq_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = bldq_pkg::DATA_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  func,
	input  logic [31:0] data_value,
	output logic        done,
	output logic [1:0]  status,
	output logic [4:0]  entry_count
);

	localparam int CNT_W = $clog2(DEPTH + 1);

	logic                  accept;
	logic                  busy_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [CNT_W-1:0]      cnt_d;
	logic                  done_q;
	logic [1:0]            status_q;
	logic [1:0]            status_d;
	logic [4:0]            entry_count_q;
	logic [DATA_WIDTH-1:0] key;
	logic                  full;
	logic                  empty;
	logic                  hit;
	logic [DEPTH-1:0]      match_w;
	logic [DATA_WIDTH-1:0] data_w [DEPTH];
	bldq_pkg::cell_ctrl_t  ctrl;

	assign accept = start && !busy_q;
	assign key    = DATA_WIDTH'(data_value);
	assign full   = cnt_q == CNT_W'(DEPTH);
	assign empty  = cnt_q == '0;
	assign hit    = |match_w;

	// row of cells, each shifting with its neighbors
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] prev_w;
		logic [DATA_WIDTH-1:0] next_w;
		if (i == 0) begin : g_first
			assign prev_w = key;
		end else begin : g_mid_prev
			assign prev_w = data_w[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign next_w = data_w[i];
		end else begin : g_mid_next
			assign next_w = data_w[i+1];
		end
		bldq_cell #(
			.DATA_WIDTH(DATA_WIDTH),
			.CNT_W     (CNT_W),
			.IDX       (i)
		) u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.count    (cnt_q),
			.key      (key),
			.prev_data(prev_w),
			.next_data(next_w),
			.data     (data_w[i]),
			.match    (match_w[i])
		);
	end

	// operation decode: cell commands, next count and status
	always_comb begin
		ctrl     = '0;
		cnt_d    = cnt_q;
		status_d = bldq_pkg::ST_ERR;
		if (accept) begin
			unique case (func)
				bldq_pkg::OP_PUSH_FRONT, bldq_pkg::OP_PUSH_BACK: begin
					if (full) begin
						status_d = bldq_pkg::ST_FULL;
					end else begin
						ctrl.shift_r = func == bldq_pkg::OP_PUSH_FRONT;
						ctrl.append  = func == bldq_pkg::OP_PUSH_BACK;
						cnt_d        = cnt_q + 1'b1;
						status_d     = bldq_pkg::ST_OK;
					end
				end
				bldq_pkg::OP_POP_FRONT, bldq_pkg::OP_POP_BACK: begin
					if (!empty) begin
						ctrl.shift_l = func == bldq_pkg::OP_POP_FRONT;
						cnt_d        = cnt_q - 1'b1;
						status_d     = bldq_pkg::ST_OK;
					end
				end
				bldq_pkg::OP_SEARCH: begin
					status_d = hit ? bldq_pkg::ST_OK : bldq_pkg::ST_ERR;
				end
				bldq_pkg::OP_CLEAR: begin
					if (!empty) begin
						cnt_d    = '0;
						status_d = bldq_pkg::ST_OK;
					end
				end
				default: begin
					status_d = bldq_pkg::ST_ERR;
				end
			endcase
		end
	end

	// count, result registers and reset busy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q        <= 1'b1;
			cnt_q         <= '0;
			done_q        <= 1'b0;
			status_q      <= bldq_pkg::ST_OK;
			entry_count_q <= '0;
		end else begin
			busy_q <= 1'b0;
			cnt_q  <= cnt_d;
			done_q <= accept;
			if (accept) begin
				status_q      <= status_d;
				entry_count_q <= 5'(cnt_d);
			end
		end
	end

	assign busy        = busy_q;
	assign done        = done_q;
	assign status      = status_q;
	assign entry_count = entry_count_q;

`ifndef SYNTHESIS
	// count never runs past the row length
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("count above depth");

	// every taken item gives one result in the next cycle
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done)
		else $error("missing result");

	// no result without an item
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> !done)
		else $error("result without item");

	// a refused push leaves the store full
	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == bldq_pkg::ST_FULL) |-> cnt_q == CNT_W'(DEPTH))
		else $error("full status on non-full store");
`endif

endmodule

[hdl/bldq_cell.sv]
// one storage cell of the deque: holds an entry, shifts, compares against the key
module bldq_cell #(
	parameter int DATA_WIDTH = bldq_pkg::DATA_WIDTH_DEF,
	parameter int CNT_W      = 5,
	parameter int IDX        = 0
) (
	input  logic                   clk,
	input  bldq_pkg::cell_ctrl_t   ctrl,
	input  logic [CNT_W-1:0]       count,
	input  logic [DATA_WIDTH-1:0]  key,
	input  logic [DATA_WIDTH-1:0]  prev_data,
	input  logic [DATA_WIDTH-1:0]  next_data,
	output logic [DATA_WIDTH-1:0]  data,
	output logic                   match
);

	logic [DATA_WIDTH-1:0] entry_q;
	logic                  occupied;

	// cell holds a live entry when its position is below the count
	assign occupied = CNT_W'(IDX) < count;
	assign match    = occupied && (entry_q == key);
	assign data     = entry_q;

	// entry register, no reset needed
	always_ff @(posedge clk) begin
		if (ctrl.shift_r) begin
			entry_q <= prev_data;
		end else if (ctrl.shift_l) begin
			entry_q <= next_data;
		end else if (ctrl.append && (count == CNT_W'(IDX))) begin
			entry_q <= key;
		end
	end

endmodule

[tb/bldq_result_checker.sv]
// result checker for the bounded deque: predicts each item's status and count and compares
`timescale 1ns / 1ps

module bldq_result_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [2:0]  func,
	input  logic [31:0] data_value,
	input  logic        done,
	input  logic [1:0]  status,
	input  logic [4:0]  entry_count,
	output int          fail_count,
	output int          results_pending
);

	localparam int DEPTH       = bldq_pkg::DEPTH_DEF;
	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic [2:0]  op;
		logic [31:0] key;
		logic [1:0]  status;
		logic [4:0]  count;
	} deque_outcome_t;

	// predicted contents of the deque, front at index 0
	logic [31:0] held_vals [0:DEPTH-1];
	int          held_count;

	// outcomes of accepted items, oldest first
	deque_outcome_t outcome_q[$];

	// apply one operation to the predicted deque
	function automatic deque_outcome_t step_deque(input logic [2:0] op, input logic [31:0] key);
		deque_outcome_t r;
		int i;
		r.op = op;
		r.key = key;
		r.status = bldq_pkg::ST_ERR;
		case (op)
			bldq_pkg::OP_PUSH_FRONT: begin
				if (held_count >= DEPTH) begin
					r.status = bldq_pkg::ST_FULL;
				end else begin
					for (i = held_count; i > 0; i--)
						held_vals[i] = held_vals[i-1];
					held_vals[0] = key;
					held_count++;
					r.status = bldq_pkg::ST_OK;
				end
			end
			bldq_pkg::OP_PUSH_BACK: begin
				if (held_count >= DEPTH) begin
					r.status = bldq_pkg::ST_FULL;
				end else begin
					held_vals[held_count] = key;
					held_count++;
					r.status = bldq_pkg::ST_OK;
				end
			end
			bldq_pkg::OP_POP_FRONT: begin
				if (held_count != 0) begin
					for (i = 0; i < held_count - 1; i++)
						held_vals[i] = held_vals[i+1];
					held_count--;
					r.status = bldq_pkg::ST_OK;
				end
			end
			bldq_pkg::OP_POP_BACK: begin
				if (held_count != 0) begin
					held_count--;
					r.status = bldq_pkg::ST_OK;
				end
			end
			bldq_pkg::OP_SEARCH: begin
				for (i = 0; i < held_count; i++)
					if (held_vals[i] == key)
						r.status = bldq_pkg::ST_OK;
			end
			bldq_pkg::OP_CLEAR: begin
				if (held_count != 0) begin
					held_count = 0;
					r.status = bldq_pkg::ST_OK;
				end
			end
			default: begin
			end
		endcase
		r.count = 5'(held_count);
		return r;
	endfunction

	// compare results first, then record the item taken at this edge
	always @(posedge clk or negedge arst_n) begin
		deque_outcome_t want;
		if (!arst_n) begin
			held_count = 0;
			outcome_q.delete();
			results_pending <= 0;
			fail_count <= 0;
		end else begin
			if (done) begin
				if (outcome_q.size() == 0) begin
					if (fail_count < REPORT_LIMIT)
						$display("%0t: result with no item outstanding: status %0d count %0d",
							$realtime, status, entry_count);
					fail_count <= fail_count + 1;
				end else begin
					want = outcome_q.pop_front();
					if (status !== want.status || entry_count !== want.count) begin
						if (fail_count < REPORT_LIMIT)
							$display("%0t: op %0d key %h: status exp %0d got %0d, count exp %0d got %0d",
								$realtime, want.op, want.key, want.status, status,
								want.count, entry_count);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (start && !busy)
				outcome_q.push_back(step_deque(func, data_value));
			results_pending <= outcome_q.size();
		end
	end

endmodule

[tb/bounded_list_deque_with_search_top_tb.sv]
// testbench top for the bounded deque with search: stimulus, watchdog and verdict
`timescale 1ns / 1ps

module bounded_list_deque_with_search_top_tb;

	localparam int DEPTH        = bldq_pkg::DEPTH_DEF;
	localparam int RANDOM_ITEMS = 1300;
	localparam int QUIET_TAIL   = 150;
	localparam int STALL_LIMIT  = 2000;
	localparam int POOL_SIZE    = 8;

	// codes the block does not define
	localparam logic [2:0] OP_UNDEF_LO = 3'd6;
	localparam logic [2:0] OP_UNDEF_HI = 3'd7;

	// traffic mixes for the random part
	localparam int MIX_FILL    = 0;
	localparam int MIX_DRAIN   = 1;
	localparam int MIX_BALANCE = 2;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [2:0]  func = bldq_pkg::OP_PUSH_FRONT;
	logic [31:0] data_value = '0;
	logic        busy;
	logic        done;
	logic [1:0]  status;
	logic [4:0]  entry_count;

	int fail_count;
	int results_pending;
	int stall_cycles = 0;

	// recently pushed values, so searches find hits
	logic [31:0] pushed_pool [0:POOL_SIZE-1];
	int          pool_wr = 0;

	bounded_list_deque_with_search_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.func        (func),
		.data_value  (data_value),
		.done        (done),
		.status      (status),
		.entry_count (entry_count)
	);

	bldq_result_checker checker_i (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.func            (func),
		.data_value      (data_value),
		.done            (done),
		.status          (status),
		.entry_count     (entry_count),
		.fail_count      (fail_count),
		.results_pending (results_pending)
	);

	// clock
	initial begin
		forever #6 clk = ~clk;
	end

	// watchdog on cycles where nothing moves
	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// offer one item and wait until it is taken
	task automatic send_item(input logic [2:0] op, input logic [31:0] key);
		start <= 1'b1;
		func <= op;
		data_value <= key;
		if (op == bldq_pkg::OP_PUSH_FRONT || op == bldq_pkg::OP_PUSH_BACK) begin
			pushed_pool[pool_wr] = key;
			pool_wr = (pool_wr + 1) % POOL_SIZE;
		end
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// idle gap with noise on the payload
	task automatic idle_gap(input int cycles);
		start <= 1'b0;
		func <= 3'($urandom);
		data_value <= $urandom;
		repeat (cycles) @(posedge clk);
	endtask

	// value for a push or search: random, extreme or recently pushed
	function automatic logic [31:0] pick_value();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return $urandom;
		else if (r < 60)
			return 32'h0;
		else if (r < 70)
			return 32'hFFFF_FFFF;
		else if (r < 75)
			return 32'h8000_0000;
		else
			return pushed_pool[$urandom_range(0, POOL_SIZE - 1)];
	endfunction

	// operation for the current traffic mix
	function automatic logic [2:0] pick_op(input int mix);
		int r;
		int push_w;
		int pop_w;
		r = $urandom_range(0, 99);
		push_w = (mix == MIX_FILL) ? 70 : (mix == MIX_DRAIN) ? 15 : 35;
		pop_w  = (mix == MIX_FILL) ? 12 : (mix == MIX_DRAIN) ? 67 : 35;
		if (r < push_w)
			return r[0] ? bldq_pkg::OP_PUSH_BACK : bldq_pkg::OP_PUSH_FRONT;
		else if (r < push_w + pop_w)
			return r[0] ? bldq_pkg::OP_POP_BACK : bldq_pkg::OP_POP_FRONT;
		else if (r < 93)
			return bldq_pkg::OP_SEARCH;
		else if (r < 97)
			return bldq_pkg::OP_CLEAR;
		else
			return r[0] ? OP_UNDEF_HI : OP_UNDEF_LO;
	endfunction

	initial begin
		int i;
		int mix;
		bit gaps_on;
		for (i = 0; i < POOL_SIZE; i++)
			pushed_pool[i] = '0;

		// reset
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty-store errors and undefined codes
		send_item(bldq_pkg::OP_CLEAR, 32'h0);
		send_item(bldq_pkg::OP_POP_FRONT, 32'h0);
		send_item(bldq_pkg::OP_POP_BACK, 32'hFFFF_FFFF);
		send_item(bldq_pkg::OP_SEARCH, 32'h0);
		send_item(OP_UNDEF_LO, 32'h1234_5678);
		send_item(OP_UNDEF_HI, 32'hFFFF_FFFF);

		// fill to capacity from both ends with extreme and walking values
		send_item(bldq_pkg::OP_PUSH_FRONT, 32'h0);
		send_item(bldq_pkg::OP_PUSH_BACK, 32'hFFFF_FFFF);
		for (i = 0; i < DEPTH - 2; i++)
			send_item(i[0] ? bldq_pkg::OP_PUSH_FRONT : bldq_pkg::OP_PUSH_BACK,
				32'h1 << (i * 2 + 1));

		// full refusals, search hit and miss, pops and clear
		send_item(bldq_pkg::OP_PUSH_FRONT, 32'hA5A5_A5A5);
		send_item(bldq_pkg::OP_PUSH_BACK, 32'h5A5A_5A5A);
		send_item(bldq_pkg::OP_SEARCH, 32'hFFFF_FFFF);
		send_item(bldq_pkg::OP_SEARCH, 32'h0000_0001);
		send_item(bldq_pkg::OP_POP_FRONT, 32'h0);
		send_item(bldq_pkg::OP_POP_BACK, 32'h0);
		send_item(bldq_pkg::OP_CLEAR, 32'h0);

		// random traffic in stretches of fill, drain and balanced mixes
		mix = MIX_FILL;
		gaps_on = 1'b1;
		for (i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 40 == 0) begin
				mix = $urandom_range(MIX_FILL, MIX_BALANCE);
				gaps_on = ($urandom_range(0, 3) != 0);
			end
			send_item(pick_op(mix), pick_value());
			if (gaps_on && i < RANDOM_ITEMS - QUIET_TAIL && $urandom_range(0, 2) == 0)
				idle_gap($urandom_range(1, 13));
		end

		// drain and settle
		idle_gap(1);
		while (results_pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
